>>> rtl/domain_suffix_matcher_top_defines.svh
// Assertion macros for the domain suffix matcher.
// Used by domain_suffix_matcher_top; expects clock and reset in scope.
`ifndef DOMAIN_SUFFIX_MATCHER_TOP_DEFINES_SVH
`define DOMAIN_SUFFIX_MATCHER_TOP_DEFINES_SVH

// expression must hold at every edge outside reset
`define DSM_ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define DSM_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/dsm_pkg.sv
// Shared types and constants for the domain suffix matcher.
// No dependencies.
`timescale 1ns / 1ps

package dsm_pkg;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_STORED   = 3'd0;
   localparam status_type STATUS_REJECTED = 3'd1;
   localparam status_type STATUS_NO_MATCH = 3'd2;
   localparam status_type STATUS_MATCH    = 3'd3;
   localparam status_type STATUS_TOO_LONG = 3'd4;

   localparam logic       ACTION_PATTERN = 1'b0;
   localparam logic       ACTION_QUERY   = 1'b1;

   localparam logic [8:0] MAX_PATTERN = 9'd255;
   localparam logic [7:0] DOT_BYTE    = 8'h2E;

endpackage

>>> rtl/dsm_ifs.sv
// Valid/ready channel interfaces for the domain suffix matcher.
// Depends on dsm_pkg.
`timescale 1ns / 1ps

interface dsm_req_if import dsm_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] char_byte;
   logic       last_char;

   modport source (output valid, action, char_byte, last_char, input ready);
   modport sink   (input valid, action, char_byte, last_char, output ready);
endinterface

interface dsm_rsp_if import dsm_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;

   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

>>> rtl/dsm_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module dsm_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/domain_suffix_matcher_top.sv
// Domain suffix matcher.
// Request words carry either a pattern character or a query name character.
// A pattern is staged behind the committed store and committed on its last
// character: status 0 if stored, 1 if over 255 characters or the store
// cannot hold its length byte plus characters (store left unchanged).
// A query name is buffered; on its last character the stored patterns are
// walked and each is compared against the tail of the name with a leading dot:
// status 3 on a suffix match, 2 otherwise, 4 if the name exceeds NAME_BYTES-1.
// Non-final characters give no response word.
// A final pattern character is accepted, then committed in the commit state.
// A final query character starts a walk over the stored patterns that stops
// at the first match: the single read port of the pattern store reads each
// length byte, then the pattern bytes one at a time through the shared
// compare unit.
// One response word is held in an output register; a new word is accepted
// while it waits only if it is taken in the same cycle, so a stalled
// receiver holds off requests. Reset clears the fill count and the pending
// lengths; store contents need no clearing.
`timescale 1ns / 1ps
`include "domain_suffix_matcher_top_defines.svh"

module domain_suffix_matcher_top import dsm_pkg::*; #(
   parameter int STORE_BYTES = 8192,
   parameter int NAME_BYTES  = 256
) (
   input logic      clock,
   input logic      reset,
   dsm_req_if.sink  req_ch,
   dsm_rsp_if.source rsp_ch
);

   localparam int AW  = $clog2(STORE_BYTES);
   localparam int FW  = $clog2(STORE_BYTES + 1);
   localparam int XW  = FW + 2;
   localparam int NAW = $clog2(NAME_BYTES);
   localparam int NW  = $clog2(NAME_BYTES + 1);
   localparam int CW  = (NAW + 1 > 8) ? NAW + 1 : 9;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_COMMIT = 3'd1;
   localparam logic [2:0] S_LEN_RD = 3'd2;
   localparam logic [2:0] S_LEN    = 3'd3;
   localparam logic [2:0] S_CMP_RD = 3'd4;
   localparam logic [2:0] S_CMP    = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [8:0]     plen_ff, plen_in;
   logic [NW-1:0]  nlen_ff, nlen_in;
   logic [NAW-1:0] n_ff, n_in;
   logic [FW-1:0]  i_ff, i_in;
   logic [7:0]     len_ff, len_in;
   logic [7:0]     p_ff, p_in;
   logic [NAW-1:0] nptr_ff, nptr_in;
   logic           dot_ff, dot_in;
   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff, rsp_status_in;

   logic           req_fire;
   logic [XW-1:0]  pos_x;
   logic [8:0]     plen_next;
   logic [NW-1:0]  nlen_next;
   logic           reject;

   logic           st_we;
   logic [AW-1:0]  st_waddr;
   logic [7:0]     st_wdata;
   logic [AW-1:0]  st_raddr;
   logic [7:0]     st_q;

   logic           nb_we;
   logic [7:0]     nb_q;

   logic [FW-1:0]  cmp_addr;
   logic [CW-1:0]  n_plus1;
   logic [7:0]     want;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;

   // staging slot of the next pattern char; in commit, end of the new pattern
   assign pos_x     = XW'(fill_ff) + XW'(plen_ff) + XW'(1);
   assign plen_next = (plen_ff <= MAX_PATTERN) ? plen_ff + 9'd1 : plen_ff;
   assign nlen_next = (nlen_ff < NW'(NAME_BYTES)) ? nlen_ff + NW'(1) : nlen_ff;
   assign reject    = (plen_ff > MAX_PATTERN) || (pos_x > XW'(STORE_BYTES));

   assign cmp_addr = i_ff + FW'(1) + FW'(p_ff);
   assign n_plus1  = CW'(n_ff) + CW'(1);
   assign want     = dot_ff ? DOT_BYTE : nb_q;

   // store write port: staged characters in idle, length byte on commit
   always_comb begin
      st_we    = 1'b0;
      st_waddr = pos_x[AW-1:0];
      st_wdata = req_ch.char_byte;
      if (state_ff == S_COMMIT) begin
         st_we    = !reject;
         st_waddr = fill_ff[AW-1:0];
         st_wdata = plen_ff[7:0];
      end else if (req_fire && req_ch.action == ACTION_PATTERN) begin
         st_we = (plen_ff < MAX_PATTERN) && (pos_x < XW'(STORE_BYTES));
      end
   end

   assign st_raddr = (state_ff == S_CMP_RD) ? cmp_addr[AW-1:0] : i_ff[AW-1:0];
   assign nb_we    = req_fire && (req_ch.action == ACTION_QUERY)
                     && (nlen_ff < NW'(NAME_BYTES));

   dsm_ram #(.DEPTH(STORE_BYTES), .WIDTH(8)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_q)
   );

   dsm_ram #(.DEPTH(NAME_BYTES), .WIDTH(8)) u_name (
      .clock   (clock),
      .wr_en   (nb_we),
      .wr_addr (nlen_ff[NAW-1:0]),
      .wr_data (req_ch.char_byte),
      .rd_addr (nptr_ff),
      .rd_data (nb_q)
   );

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      plen_in       = plen_ff;
      nlen_in       = nlen_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      len_in        = len_ff;
      p_in          = p_ff;
      nptr_in       = nptr_ff;
      dot_in        = dot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.action == ACTION_PATTERN) begin
                  plen_in = plen_next;
                  if (req_ch.last_char) begin
                     state_in = S_COMMIT;
                  end
               end else begin
                  nlen_in = nlen_next;
                  if (req_ch.last_char) begin
                     nlen_in = '0;
                     if (nlen_next > NW'(NAME_BYTES - 1)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_TOO_LONG;
                     end else begin
                        n_in     = nlen_next[NAW-1:0];
                        i_in     = '0;
                        state_in = S_LEN_RD;
                     end
                  end
               end
            end
         end
         S_COMMIT: begin
            plen_in      = '0;
            rsp_valid_in = 1'b1;
            if (reject) begin
               rsp_status_in = STATUS_REJECTED;
            end else begin
               rsp_status_in = STATUS_STORED;
               fill_in       = pos_x[FW-1:0];
            end
            state_in = S_IDLE;
         end
         S_LEN_RD: begin
            if (i_ff >= fill_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_MATCH;
               state_in      = S_IDLE;
            end else begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (CW'(st_q) <= n_plus1) begin
               len_in   = st_q;
               p_in     = '0;
               dot_in   = (CW'(st_q) == n_plus1);
               // wraps to all ones for the dot case, then steps to entry 0
               nptr_in  = NAW'(CW'(n_ff) - CW'(st_q));
               state_in = S_CMP_RD;
            end else begin
               i_in     = i_ff + FW'(1) + FW'(st_q);
               state_in = S_LEN_RD;
            end
         end
         S_CMP_RD: begin
            if (p_ff == len_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_MATCH;
               state_in      = S_IDLE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (st_q == want) begin
               p_in     = p_ff + 8'd1;
               nptr_in  = nptr_ff + NAW'(1);
               dot_in   = 1'b0;
               state_in = S_CMP_RD;
            end else begin
               i_in     = i_ff + FW'(1) + FW'(len_ff);
               state_in = S_LEN_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         plen_ff      <= '0;
         nlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         plen_ff      <= plen_in;
         nlen_ff      <= nlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      i_ff          <= i_in;
      len_ff        <= len_in;
      p_ff          <= p_in;
      nptr_ff       <= nptr_in;
      dot_ff        <= dot_in;
      rsp_status_ff <= rsp_status_in;
   end

   `DSM_ASSERT_HOLDS(a_fill_bound, XW'(fill_ff) <= XW'(STORE_BYTES), "store fill past end")
   `DSM_ASSERT_IMPLIES(a_busy_not_ready, state_ff != S_IDLE, !req_ch.ready, "ready while busy")
   `DSM_ASSERT_IMPLIES(a_busy_rsp_free, state_ff != S_IDLE, !rsp_valid_ff, "response pending while busy")
   `DSM_ASSERT_IMPLIES(a_cmp_in_pattern, state_ff == S_CMP, p_ff < len_ff, "compare past pattern end")

endmodule
